/* rtl/core/srrip_pkg.sv */
// Shared constants, types and helpers for the SRRIP replacement block.
`default_nettype none

package srrip_pkg;

    localparam int SET_COUNT = 64;
    localparam int WAY_COUNT = 8;

    localparam int RRPV_W   = 8;
    localparam int SET_AW   = $clog2(SET_COUNT);
    localparam int WAY_AW   = $clog2(WAY_COUNT);
    localparam int ROW_W    = WAY_COUNT * RRPV_W;

    // port field widths
    localparam int FUNC_W   = 3;
    localparam int SET_W    = 6;
    localparam int WAY_W    = 3;
    localparam int BITS_W   = 4;

    localparam logic [BITS_W-1:0] RRPV_BITS_RESET = 4'd2;

    localparam logic [FUNC_W-1:0] FUNC_HIT    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_VICTIM = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_INVAL  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

    // register index within the config space
    localparam logic REG_RRPV_BITS = 1'b0;

    typedef logic [RRPV_W-1:0] rrpv_t;
    typedef rrpv_t [WAY_COUNT-1:0] row_t;

    typedef struct packed {
        row_t              row;
        logic [WAY_AW-1:0] victim;
    } age_res_t;

    // widths outside 1..8 saturate to the nearest legal width
    function automatic rrpv_t max_value(input logic [BITS_W-1:0] bits);
        logic [BITS_W-1:0] b;
        logic [RRPV_W:0]   one;
        b   = bits;
        one = (RRPV_W+1)'(1);
        if (b < 4'd1)
        begin
            b = 4'd1;
        end
        if (b > 4'd8)
        begin
            b = 4'd8;
        end
        return RRPV_W'((one << b) - one);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/srrip_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module srrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/srrip_cfg.sv */
// APB-style register port holding the RRPV width setting.
`default_nettype none

module srrip_cfg
    import srrip_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output rrpv_t            max_rrpv
);

    logic [BITS_W-1:0] rrpv_bits_reg;
    logic [BITS_W-1:0] rrpv_bits_next;
    logic              wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_RRPV_BITS);

    always_comb
    begin
        rrpv_bits_next = rrpv_bits_reg;
        if (wr_hit)
        begin
            rrpv_bits_next = pwdata[BITS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rrpv_bits_reg <= RRPV_BITS_RESET;
        end
        else
        begin
            rrpv_bits_reg <= rrpv_bits_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_RRPV_BITS)
        begin
            prdata = {{(32-BITS_W){1'b0}}, rrpv_bits_reg};
        end
    end

    assign max_rrpv = max_value(rrpv_bits_reg);

endmodule

`default_nettype wire

/* rtl/core/srrip_row.sv */
// Row datapath: clamp and maximum of a set row, then aging and victim pick.
`default_nettype none

module srrip_row
    import srrip_pkg::*;
(
    input  wire rrpv_t max_rrpv,
    // first half: raw row as read
    input  wire row_t  raw_row,
    output row_t       clamp_row,
    output rrpv_t      top,
    // second half: registered clamp row and its maximum
    input  wire row_t  age_row_in,
    input  wire rrpv_t age_top,
    output age_res_t   age_res
);

    rrpv_t            deficit;
    logic [RRPV_W:0]  sum;

    // values left over from a wider setting read as max
    always_comb
    begin
        top = '0;
        for (int w = 0; w < WAY_COUNT; w++)
        begin
            clamp_row[w] = (raw_row[w] > max_rrpv) ? max_rrpv : raw_row[w];
            if (clamp_row[w] > top)
            begin
                top = clamp_row[w];
            end
        end
    end

    always_comb
    begin
        deficit        = max_rrpv - age_top;
        sum            = '0;
        age_res.row    = age_row_in;
        age_res.victim = '0;
        for (int w = 0; w < WAY_COUNT; w++)
        begin
            sum = {1'b0, age_row_in[w]} + {1'b0, deficit};
            age_res.row[w] = (sum > {1'b0, max_rrpv}) ? max_rrpv : sum[RRPV_W-1:0];
        end
        // lowest way at max wins
        for (int w = WAY_COUNT - 1; w >= 0; w--)
        begin
            if (age_res.row[w] == max_rrpv)
            begin
                age_res.victim = WAY_AW'(w);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/srrip_replacement_top.sv */
// SRRIP replacement top: set-row RAM, read-modify-write sequencer, result word.
// Hit, insert and invalidate read the row once accepted, then write the changed row back.
// Find victim reads the row, registers its clamp and max, then ages and writes it back;
// the result word shows with that write. Clear-all and unused codes leave it idle.
// A request is taken only in idle, so it waits for the last one to finish; a victim
// is held in aging while the previous word is unread. Reset clears the row valid bits
// at once; unwritten rows read as the max for the reset width.
`default_nettype none

module srrip_replacement_top
    import srrip_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // request channel
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [FUNC_W-1:0] func,
    input  wire logic [SET_W-1:0]  set_index,
    input  wire logic [WAY_W-1:0]  way_index,
    // victim channel
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [WAY_W-1:0]  victim_way,
    output logic      [SET_W-1:0]  victim_set,
    // config port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_WB   = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [FUNC_W-1:0]    func_reg, func_next;
    logic [SET_W-1:0]     set_reg, set_next;
    logic [WAY_W-1:0]     way_reg, way_next;
    row_t                 clamp_row_reg, clamp_row_next;
    rrpv_t                top_reg, top_next;
    logic [SET_COUNT-1:0] valid_reg, valid_next;
    rrpv_t                fill_reg, fill_next;
    logic                 out_valid_reg, out_valid_next;
    logic [WAY_W-1:0]     victim_way_reg, victim_way_next;
    logic [SET_W-1:0]     victim_set_reg, victim_set_next;

    rrpv_t               max_rrpv;
    logic                accept;
    logic                set_ok, way_ok;
    logic                wb_go;
    logic [ROW_W-1:0]    rd_data;
    row_t                raw_row;
    row_t                clamp_row;
    rrpv_t               top;
    age_res_t            age_res;
    row_t                mod_row;
    logic                wr_en;
    logic [ROW_W-1:0]    wr_data;
    logic [SET_AW-1:0]   row_addr;

    srrip_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .max_rrpv (max_rrpv)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign row_addr = set_reg[SET_AW-1:0];
    assign set_ok   = 32'(set_reg) < SET_COUNT;
    assign way_ok   = 32'(way_reg) < WAY_COUNT;
    assign wb_go    = !out_valid_reg || out_ready;

    srrip_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SET_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (row_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (set_index[SET_AW-1:0]),
        .rd_data (rd_data)
    );

    // rows not written since the last clear read as the fill value
    assign raw_row = valid_reg[row_addr] ? row_t'(rd_data) : {WAY_COUNT{fill_reg}};

    srrip_row u_row (
        .max_rrpv   (max_rrpv),
        .raw_row    (raw_row),
        .clamp_row  (clamp_row),
        .top        (top),
        .age_row_in (clamp_row_reg),
        .age_top    (top_reg),
        .age_res    (age_res)
    );

    // single-way update keeps the other ways as stored
    always_comb
    begin
        mod_row = raw_row;
        case (func_reg)
            FUNC_HIT:    mod_row[way_reg[WAY_AW-1:0]] = '0;
            FUNC_INSERT: mod_row[way_reg[WAY_AW-1:0]] = max_rrpv - rrpv_t'(1);
            FUNC_INVAL:  mod_row[way_reg[WAY_AW-1:0]] = max_rrpv;
            default:     mod_row = raw_row;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        set_next        = set_reg;
        way_next        = way_reg;
        clamp_row_next  = clamp_row_reg;
        top_next        = top_reg;
        valid_next      = valid_reg;
        fill_next       = fill_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        victim_way_next = victim_way_reg;
        victim_set_next = victim_set_reg;
        wr_en           = 1'b0;
        wr_data         = mod_row;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next = func;
                    set_next  = set_index;
                    way_next  = way_index;
                    if (func == FUNC_CLEAR)
                    begin
                        valid_next = '0;
                        fill_next  = max_rrpv;
                    end
                    else if (func inside {FUNC_HIT, FUNC_INSERT, FUNC_VICTIM, FUNC_INVAL})
                    begin
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                if (func_reg == FUNC_VICTIM)
                begin
                    clamp_row_next = clamp_row;
                    top_next       = top;
                    state_next     = ST_WB;
                end
                else
                begin
                    wr_en      = set_ok && way_ok;
                    state_next = ST_IDLE;
                end
            end
            ST_WB:
            begin
                wr_data = age_res.row;
                if (wb_go)
                begin
                    wr_en           = set_ok;
                    out_valid_next  = 1'b1;
                    victim_way_next = set_ok ? WAY_W'(age_res.victim) : '0;
                    victim_set_next = set_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (wr_en)
        begin
            valid_next[row_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            fill_reg      <= max_value(RRPV_BITS_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        set_reg        <= set_next;
        way_reg        <= way_next;
        clamp_row_reg  <= clamp_row_next;
        top_reg        <= top_next;
        victim_way_reg <= victim_way_next;
        victim_set_reg <= victim_set_next;
    end

    assign out_valid  = out_valid_reg;
    assign victim_way = victim_way_reg;
    assign victim_set = victim_set_reg;

    // a word is only produced by the aging stage
    a_out_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_WB))
        else $error("victim word without aging step");

    // RAM is never written while a new request can be taken
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg != ST_IDLE))
        else $error("row write in idle");

    // the picked way really sits at max after aging
    a_victim_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB) |-> (age_res.row[age_res.victim] == max_rrpv))
        else $error("victim way not at max");

    // clear-all drops every row to the fill value
    a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_CLEAR)) |=> (valid_reg == '0))
        else $error("clear-all left a valid row");

endmodule

`default_nettype wire
